FILE: rtl/core/linked_block_chain_allocator_assert.svh
// ----------------------------------------------------------------------------
// Block chain allocator assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LINKED_BLOCK_CHAIN_ALLOCATOR_ASSERT_SVH
`define LINKED_BLOCK_CHAIN_ALLOCATOR_ASSERT_SVH

// Check that is switched off while reset is applied.
`define LBCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that also holds during reset.
`define LBCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/lbca_pkg.sv
// ----------------------------------------------------------------------------
// Block chain allocator package
// Field widths, command and status codes and the sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbca_pkg;

  localparam int WORD_BITS = 64;
  localparam int OPW       = 3;
  localparam int IDW       = 8;
  localparam int SIZEW     = 24;
  localparam int BSW       = 16;
  localparam int ACTW      = 9;
  localparam int STW       = 2;
  localparam int BTW       = 9;
  localparam int CFGW      = 16;

  // Command codes.
  localparam logic [OPW-1:0] OP_WRITE  = 3'd0;
  localparam logic [OPW-1:0] OP_APPEND = 3'd1;
  localparam logic [OPW-1:0] OP_REMOVE = 3'd2;
  localparam logic [OPW-1:0] OP_QUERY  = 3'd3;
  localparam logic [OPW-1:0] OP_HEAD   = 3'd4;
  localparam logic [OPW-1:0] OP_NEXT   = 3'd5;

  // Status codes.
  localparam logic [STW-1:0] ST_OK      = 2'd0;
  localparam logic [STW-1:0] ST_RANGE   = 2'd1;
  localparam logic [STW-1:0] ST_NOSPACE = 2'd2;
  localparam logic [STW-1:0] ST_EMPTY   = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_ACTIVE = 1'b0;
  localparam logic CFG_BSIZE  = 1'b1;

  typedef enum logic [19:0] {
    S_CLEAR   = 20'h00001,
    S_IDLE    = 20'h00002,
    S_FC_HREQ = 20'h00004,
    S_FC_HCHK = 20'h00008,
    S_WK_REQ  = 20'h00010,
    S_WK_UPD  = 20'h00020,
    S_FC_END  = 20'h00040,
    S_DIV     = 20'h00080,
    S_SC_LOAD = 20'h00100,
    S_SC_WAIT = 20'h00200,
    S_SC_BIT  = 20'h00400,
    S_AL_END  = 20'h00800,
    S_HS_REQ  = 20'h01000,
    S_HS_CHK  = 20'h02000,
    S_QB_REQ  = 20'h04000,
    S_QB_RSP  = 20'h08000,
    S_GH_REQ  = 20'h10000,
    S_GH_RSP  = 20'h20000,
    S_LN_REQ  = 20'h40000,
    S_LN_RSP  = 20'h80000
  } state_e;

endpackage

FILE: rtl/core/linked_block_chain_allocator.sv
// ----------------------------------------------------------------------------
// Linked block chain allocator
// Free bitmap, per-ID chain heads and next links for a pool of blocks.
// ----------------------------------------------------------------------------
// Usage: a command item is taken when start_i is high and busy_o is low.
// Exactly one result item follows, shown for one cycle with done_o high;
// the receiver cannot stall it, and the next command may be issued in the
// same cycle that done_o is high.
// Write and append run a serial divider that turns the size into a block
// count, then a bitmap scan, one block per cycle outside the word loads
// (free count, then allocation); append first searches for the lowest unused ID.
// One command at a time. After reset a clearing pass empties the head table
// and frees the bitmap; busy_o stays high meanwhile. Configuration writes
// are taken at any time through cfg_we_i.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linked_block_chain_allocator #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [lbca_pkg::CFGW-1:0]     cfg_data_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [lbca_pkg::OPW-1:0]      opcode_i,
  input  logic [lbca_pkg::IDW-1:0]      data_id_i,
  input  logic [lbca_pkg::IDW-1:0]      block_index_i,
  input  logic [lbca_pkg::SIZEW-1:0]    data_size_i,
  output logic                          done_o,
  output logic [lbca_pkg::STW-1:0]      status_o,
  output logic [lbca_pkg::IDW-1:0]      id_out_o,
  output logic [lbca_pkg::IDW-1:0]      block_out_o,
  output logic                          flag_o,
  output logic [lbca_pkg::BSW-1:0]      last_fill_o,
  output logic [lbca_pkg::BTW-1:0]      blocks_taken_o
);

  import lbca_pkg::*;

  localparam int AW    = $clog2(MAX_BLOCKS);
  localparam int CW    = $clog2(MAX_BLOCKS + 1);
  localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;

  // Configuration registers.
  logic [ACTW-1:0] active_q;
  logic [BSW-1:0]  bsize_q;

  // Sequencer and working registers.
  state_e           state_q, state_d;
  logic [OPW-1:0]   op_q, op_d;
  logic [AW-1:0]    tgt_q, tgt_d;
  logic [IDW-1:0]   blk_q, blk_d;
  logic [SIZEW-1:0] size_q, size_d;
  logic [CW-1:0]    b_q, b_d;
  logic [CW-1:0]    steps_q, steps_d;
  logic [AW-1:0]    prev_q, prev_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    taken_q, taken_d;
  logic [CW-1:0]    avail_q, avail_d;
  logic [63:0]      word_q, word_d;
  logic             alloc_q, alloc_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [BSW:0]     rem_q, rem_d;
  logic [SIZEW-1:0] quo_q, quo_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [IDW-1:0]   rid_q, rid_d;

  // Result registers.
  logic             done_q;
  logic [STW-1:0]   status_q;
  logic [IDW-1:0]   id_q;
  logic [IDW-1:0]   bout_q;
  logic             flag_q;
  logic [BSW-1:0]   fill_q;
  logic [BTW-1:0]   btk_q;

  // Result produced this cycle.
  logic             res_v;
  logic [STW-1:0]   res_st;
  logic [IDW-1:0]   res_id;
  logic [IDW-1:0]   res_blk;
  logic             res_flag;
  logic [BSW-1:0]   res_fill;
  logic [BTW-1:0]   res_btk;

  // Memories and their ports.
  logic [63:0]   fm_mem [WORDS];
  logic [AW:0]   hd_mem [MAX_BLOCKS];
  logic [AW:0]   ln_mem [MAX_BLOCKS];
  logic [63:0]   fm_rd_q;
  logic [AW:0]   hd_rd_q;
  logic [AW:0]   ln_rd_q;
  logic          fm_we, hd_we, ln_we;
  logic [WIW-1:0] fm_waddr, fm_raddr;
  logic [AW-1:0] hd_waddr, hd_raddr, ln_waddr, ln_raddr;
  logic [63:0]   fm_wdata;
  logic [AW:0]   hd_wdata, ln_wdata;

  // Derived values.
  logic [CW-1:0]    n_w;
  logic             b_ge_n;
  logic             bit_free;
  logic [63:0]      word_clr;
  logic [BSW:0]     rem_sh;
  logic             rem_ge;
  logic [SIZEW-1:0] need_w;
  logic [BSW-1:0]   fill_w;

  // Effective block count, clamped to the built size.
  assign n_w = (32'(active_q) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(active_q);

  assign b_ge_n   = 32'(b_q) >= 32'(n_w);
  assign bit_free = word_q[b_q[5:0]];
  assign word_clr = word_q & ~(64'd1 << b_q[5:0]);

  // Restoring divider step and the block count it yields.
  assign rem_sh = {rem_q[BSW-1:0], quo_q[SIZEW-1]};
  assign rem_ge = rem_sh >= {1'b0, bsize_q};
  assign need_w = quo_q + SIZEW'(rem_q != '0);
  assign fill_w = (rem_q != '0) ? rem_q[BSW-1:0] : bsize_q;

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    tgt_d    = tgt_q;
    blk_d    = blk_q;
    size_d   = size_q;
    b_d      = b_q;
    steps_d  = steps_q;
    prev_d   = prev_q;
    head_d   = head_q;
    taken_d  = taken_q;
    avail_d  = avail_q;
    word_d   = word_q;
    alloc_d  = alloc_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    clr_d    = clr_q;
    rid_d    = rid_q;
    res_v    = 1'b0;
    res_st   = ST_OK;
    res_id   = '0;
    res_blk  = '0;
    res_flag = 1'b0;
    res_fill = '0;
    res_btk  = '0;
    fm_we    = 1'b0;
    fm_waddr = '0;
    fm_wdata = '0;
    fm_raddr = '0;
    hd_we    = 1'b0;
    hd_waddr = tgt_q;
    hd_wdata = '0;
    hd_raddr = tgt_q;
    ln_we    = 1'b0;
    ln_waddr = prev_q;
    ln_wdata = '0;
    ln_raddr = AW'(blk_q);

    unique case (state_q)
      // Empty every head and free every block after reset.
      S_CLEAR: begin
        hd_we    = 1'b1;
        hd_waddr = clr_q;
        if (32'(clr_q) < WORDS) begin
          fm_we    = 1'b1;
          fm_waddr = WIW'(clr_q);
          fm_wdata = '1;
        end
        clr_d = clr_q + AW'(1);
        if (32'(clr_q) == MAX_BLOCKS - 1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start_i) begin
          op_d   = opcode_i;
          tgt_d  = AW'(data_id_i);
          blk_d  = block_index_i;
          size_d = data_size_i;
          rid_d  = data_id_i;
          unique case (opcode_i) inside
            OP_WRITE, OP_REMOVE: begin
              if (32'(data_id_i) >= 32'(n_w)) begin
                res_v  = 1'b1;
                res_st = ST_RANGE;
                res_id = data_id_i;
              end else begin
                state_d = S_FC_HREQ;
              end
            end
            OP_APPEND: begin
              rid_d   = '0;
              b_d     = '0;
              state_d = S_HS_REQ;
            end
            OP_QUERY: begin
              if (32'(block_index_i) >= 32'(n_w)) begin
                res_v  = 1'b1;
                res_st = ST_RANGE;
              end else begin
                state_d = S_QB_REQ;
              end
            end
            OP_HEAD: begin
              if (32'(data_id_i) >= 32'(n_w)) begin
                res_v  = 1'b1;
                res_st = ST_RANGE;
                res_id = data_id_i;
              end else begin
                state_d = S_GH_REQ;
              end
            end
            OP_NEXT: begin
              if (32'(block_index_i) >= 32'(n_w)) begin
                res_v  = 1'b1;
                res_st = ST_RANGE;
              end else begin
                state_d = S_LN_REQ;
              end
            end
            default: begin
              res_v  = 1'b1;
              res_st = ST_RANGE;
            end
          endcase
        end
      end

      // Search the head table for the lowest empty ID.
      S_HS_REQ: begin
        hd_raddr = AW'(b_q);
        if (b_ge_n) begin
          res_v   = 1'b1;
          res_st  = ST_NOSPACE;
          state_d = S_IDLE;
        end else begin
          state_d = S_HS_CHK;
        end
      end

      S_HS_CHK: begin
        if (!hd_rd_q[AW]) begin
          tgt_d   = AW'(b_q);
          rid_d   = IDW'(b_q);
          state_d = S_FC_HREQ;
        end else begin
          b_d     = b_q + CW'(1);
          state_d = S_HS_REQ;
        end
      end

      // Release the old chain of the target ID.
      S_FC_HREQ: begin
        state_d = S_FC_HCHK;
      end

      S_FC_HCHK: begin
        if (hd_rd_q[AW]) begin
          b_d     = CW'(hd_rd_q[AW-1:0]);
          steps_d = '0;
          state_d = S_WK_REQ;
        end else begin
          state_d = S_FC_END;
        end
      end

      S_WK_REQ: begin
        fm_raddr = WIW'(b_q >> 6);
        ln_raddr = AW'(b_q);
        if (b_ge_n || (steps_q >= n_w)) begin
          state_d = S_FC_END;
        end else begin
          state_d = S_WK_UPD;
        end
      end

      // The word was written back before the next read is issued.
      S_WK_UPD: begin
        fm_we    = 1'b1;
        fm_waddr = WIW'(b_q >> 6);
        fm_wdata = fm_rd_q | (64'd1 << b_q[5:0]);
        if (ln_rd_q[AW]) begin
          state_d = S_FC_END;
        end else begin
          b_d     = CW'(ln_rd_q[AW-1:0]);
          steps_d = steps_q + CW'(1);
          state_d = S_WK_REQ;
        end
      end

      S_FC_END: begin
        hd_we    = 1'b1;
        hd_waddr = tgt_q;
        if (op_q == OP_REMOVE) begin
          res_v   = 1'b1;
          res_id  = rid_q;
          state_d = S_IDLE;
        end else if (size_q == '0) begin
          res_v   = 1'b1;
          res_st  = ST_EMPTY;
          res_id  = rid_q;
          state_d = S_IDLE;
        end else if (bsize_q == '0) begin
          res_v   = 1'b1;
          res_st  = ST_NOSPACE;
          res_id  = rid_q;
          state_d = S_IDLE;
        end else begin
          rem_d   = '0;
          quo_d   = size_q;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end

      // One quotient bit per cycle.
      S_DIV: begin
        rem_d = rem_ge ? (rem_sh - {1'b0, bsize_q}) : rem_sh;
        quo_d = {quo_q[SIZEW-2:0], rem_ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(SIZEW - 1)) begin
          b_d     = '0;
          avail_d = '0;
          alloc_d = 1'b0;
          state_d = S_SC_LOAD;
        end
      end

      // Bitmap scan, one block per cycle outside the word loads, one word loaded at a time.
      S_SC_LOAD: begin
        fm_raddr = WIW'(b_q >> 6);
        state_d  = S_SC_WAIT;
      end

      S_SC_WAIT: begin
        word_d  = fm_rd_q;
        state_d = S_SC_BIT;
      end

      S_SC_BIT: begin
        if (!alloc_q) begin
          // Counting pass.
          if (b_ge_n) begin
            if (need_w > SIZEW'(avail_q)) begin
              res_v   = 1'b1;
              res_st  = ST_NOSPACE;
              res_id  = rid_q;
              state_d = S_IDLE;
            end else begin
              alloc_d = 1'b1;
              b_d     = '0;
              taken_d = '0;
              state_d = S_SC_LOAD;
            end
          end else begin
            avail_d = avail_q + CW'(bit_free);
            b_d     = b_q + CW'(1);
            if (b_q[5:0] == 6'd63) begin
              state_d = S_SC_LOAD;
            end
          end
        end else begin
          // Allocation pass: take free blocks in order and link them.
          if (bit_free) begin
            word_d  = word_clr;
            prev_d  = AW'(b_q);
            taken_d = taken_q + CW'(1);
            if (taken_q == '0) begin
              hd_we    = 1'b1;
              hd_waddr = tgt_q;
              hd_wdata = {1'b1, AW'(b_q)};
              head_d   = AW'(b_q);
            end else begin
              ln_we    = 1'b1;
              ln_waddr = prev_q;
              ln_wdata = {1'b0, AW'(b_q)};
            end
          end
          if (bit_free && (SIZEW'(taken_q) + SIZEW'(1) == need_w)) begin
            state_d = S_AL_END;
          end else begin
            b_d = b_q + CW'(1);
            if (b_q[5:0] == 6'd63) begin
              fm_we    = 1'b1;
              fm_waddr = WIW'(b_q >> 6);
              fm_wdata = word_d;
              state_d  = S_SC_LOAD;
            end
          end
        end
      end

      // Write back the last word and mark the chain end.
      S_AL_END: begin
        fm_we    = 1'b1;
        fm_waddr = WIW'(prev_q >> 6);
        fm_wdata = word_q;
        ln_we    = 1'b1;
        ln_waddr = prev_q;
        ln_wdata = {1'b1, AW'(0)};
        res_v    = 1'b1;
        res_id   = rid_q;
        res_blk  = IDW'(head_q);
        res_fill = fill_w;
        res_btk  = BTW'(need_w);
        state_d  = S_IDLE;
      end

      S_QB_REQ: begin
        fm_raddr = WIW'(blk_q >> 6);
        state_d  = S_QB_RSP;
      end

      S_QB_RSP: begin
        res_v    = 1'b1;
        res_flag = !fm_rd_q[blk_q[5:0]];
        state_d  = S_IDLE;
      end

      S_GH_REQ: begin
        state_d = S_GH_RSP;
      end

      S_GH_RSP: begin
        res_v  = 1'b1;
        res_id = rid_q;
        if (hd_rd_q[AW]) begin
          res_blk = IDW'(hd_rd_q[AW-1:0]);
        end else begin
          res_st = ST_EMPTY;
        end
        state_d = S_IDLE;
      end

      S_LN_REQ: begin
        state_d = S_LN_RSP;
      end

      S_LN_RSP: begin
        res_v = 1'b1;
        if (ln_rd_q[AW]) begin
          res_flag = 1'b1;
        end else begin
          res_blk = IDW'(ln_rd_q[AW-1:0]);
        end
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (res_v) begin
      state_d = S_IDLE;
    end
  end

  // Control, working and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      active_q <= 9'd256;
      bsize_q  <= 16'd64;
      op_q     <= '0;
      tgt_q    <= '0;
      blk_q    <= '0;
      size_q   <= '0;
      b_q      <= '0;
      steps_q  <= '0;
      prev_q   <= '0;
      head_q   <= '0;
      taken_q  <= '0;
      avail_q  <= '0;
      word_q   <= '0;
      alloc_q  <= 1'b0;
      cnt_q    <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
      clr_q    <= '0;
      rid_q    <= '0;
      done_q   <= 1'b0;
      status_q <= '0;
      id_q     <= '0;
      bout_q   <= '0;
      flag_q   <= 1'b0;
      fill_q   <= '0;
      btk_q    <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      tgt_q   <= tgt_d;
      blk_q   <= blk_d;
      size_q  <= size_d;
      b_q     <= b_d;
      steps_q <= steps_d;
      prev_q  <= prev_d;
      head_q  <= head_d;
      taken_q <= taken_d;
      avail_q <= avail_d;
      word_q  <= word_d;
      alloc_q <= alloc_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      quo_q   <= quo_d;
      clr_q   <= clr_d;
      rid_q   <= rid_d;
      done_q  <= res_v;
      if (res_v) begin
        status_q <= res_st;
        id_q     <= res_id;
        bout_q   <= res_blk;
        flag_q   <= res_flag;
        fill_q   <= res_fill;
        btk_q    <= res_btk;
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_ACTIVE) begin
          active_q <= cfg_data_i[ACTW-1:0];
        end else if (cfg_index_i == CFG_BSIZE) begin
          bsize_q <= cfg_data_i[BSW-1:0];
        end
      end
    end
  end

  // Free bitmap memory.
  always_ff @(posedge clk_i) begin
    fm_rd_q <= fm_mem[fm_raddr];
    if (fm_we) begin
      fm_mem[fm_waddr] <= fm_wdata;
    end
  end

  // Chain head memory: valid bit over the head block.
  always_ff @(posedge clk_i) begin
    hd_rd_q <= hd_mem[hd_raddr];
    if (hd_we) begin
      hd_mem[hd_waddr] <= hd_wdata;
    end
  end

  // Next link memory: end bit over the next block.
  always_ff @(posedge clk_i) begin
    ln_rd_q <= ln_mem[ln_raddr];
    if (ln_we) begin
      ln_mem[ln_waddr] <= ln_wdata;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign id_out_o       = id_q;
  assign block_out_o    = bout_q;
  assign flag_o         = flag_q;
  assign last_fill_o    = fill_q;
  assign blocks_taken_o = btk_q;

  // Assertions.
  `include "linked_block_chain_allocator_assert.svh"

  `LBCA_ASSERT_ALWAYS(a_done_idle, done_q |-> (state_q == S_IDLE), "result shown while not idle")
  `LBCA_ASSERT(a_accept_moves, (start_i && !busy_o) |=> (done_o || busy_o), "command item dropped")
  `LBCA_ASSERT(a_alloc_in_range, (state_q == S_SC_BIT && alloc_q) |-> (32'(b_q) < 32'(n_w)), "allocation ran past the pool")

endmodule

FILE: bench/linked_block_chain_allocator_tb.sv
// ----------------------------------------------------------------------------
// Block chain allocator testbench
// Drives command items through several pool sizes and block sizes, predicts
// every result from a local copy of the bitmap, head and link tables, and
// checks each result field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linked_block_chain_allocator_tb;
  import lbca_pkg::*;

  typedef struct {
    logic [OPW-1:0]   op;
    logic [IDW-1:0]   id;
    logic [IDW-1:0]   blk;
    logic [SIZEW-1:0] size;
  } cmd_t;

  typedef struct {
    logic [STW-1:0] st;
    logic [IDW-1:0] id;
    logic [IDW-1:0] blk;
    logic           fl;
    logic [BSW-1:0] fill;
    logic [BTW-1:0] taken;
  } res_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_index_i = CFG_ACTIVE;
  logic [CFGW-1:0]  cfg_data_i = '0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic [OPW-1:0]   opcode_i = OP_WRITE;
  logic [IDW-1:0]   data_id_i = '0;
  logic [IDW-1:0]   block_index_i = '0;
  logic [SIZEW-1:0] data_size_i = '0;
  logic             done_o;
  logic [STW-1:0]   status_o;
  logic [IDW-1:0]   id_out_o;
  logic [IDW-1:0]   block_out_o;
  logic             flag_o;
  logic [BSW-1:0]   last_fill_o;
  logic [BTW-1:0]   blocks_taken_o;

  linked_block_chain_allocator uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow state of the pool.
  logic [8:0]  pool_active = 9'd256;
  logic [15:0] pool_bsize = 16'd64;
  logic [63:0] free_words [4];
  logic [7:0]  head_blk [256];
  logic        head_ok [256];
  logic [7:0]  next_blk [256];
  logic        is_last [256];
  logic        link_set [256];

  cmd_t cmd_q [$];
  res_t pending_q [$];
  bit   failed = 0;
  bit   took = 0;
  bit   quiet = 0;
  int   gap_left = 0;

  function automatic int pool_n();
    return (pool_active > 256) ? 256 : int'(pool_active);
  endfunction

  function automatic bit blk_free(int b);
    return free_words[b / 64][b % 64];
  endfunction

  function automatic void release_chain(int id, int n);
    int b;
    if (!head_ok[id]) return;
    b = head_blk[id];
    for (int s = 0; s < n; s++) begin
      if (b >= n) break;
      free_words[b / 64][b % 64] = 1'b1;
      if (is_last[b]) break;
      b = next_blk[b];
    end
    head_ok[id] = 1'b0;
  endfunction

  // Frees the old chain, then allocates the lowest free blocks in order.
  function automatic void alloc_chain(int id, int size, int n, inout res_t r);
    int need, avail, taken, prev;
    avail = 0;
    taken = 0;
    prev = 0;
    release_chain(id, n);
    if (size == 0) begin
      r.st = ST_EMPTY;
      return;
    end
    if (pool_bsize == 0) begin
      r.st = ST_NOSPACE;
      return;
    end
    need = (size + int'(pool_bsize) - 1) / int'(pool_bsize);
    for (int b = 0; b < n; b++) if (blk_free(b)) avail++;
    if (need > avail) begin
      r.st = ST_NOSPACE;
      return;
    end
    for (int b = 0; b < n && taken < need; b++) begin
      if (!blk_free(b)) continue;
      free_words[b / 64][b % 64] = 1'b0;
      if (taken == 0) begin
        head_blk[id] = b[7:0];
        head_ok[id] = 1'b1;
      end else begin
        next_blk[prev] = b[7:0];
        is_last[prev] = 1'b0;
        link_set[prev] = 1'b1;
      end
      prev = b;
      taken++;
    end
    next_blk[prev] = '0;
    is_last[prev] = 1'b1;
    link_set[prev] = 1'b1;
    r.st = ST_OK;
    r.blk = head_blk[id];
    r.fill = 16'(size - (need - 1) * int'(pool_bsize));
    r.taken = 9'(need);
  endfunction

  function automatic res_t predict_result(cmd_t c);
    res_t r;
    int n, i;
    n = pool_n();
    r = '{ST_OK, '0, '0, 1'b0, '0, '0};
    case (c.op)
      OP_WRITE: begin
        r.id = c.id;
        if (c.id >= n) r.st = ST_RANGE;
        else alloc_chain(c.id, int'(c.size), n, r);
      end
      OP_APPEND: begin
        for (i = 0; i < n; i++) if (!head_ok[i]) break;
        if (i >= n) r.st = ST_NOSPACE;
        else begin
          r.id = i[7:0];
          alloc_chain(i, int'(c.size), n, r);
        end
      end
      OP_REMOVE: begin
        r.id = c.id;
        if (c.id >= n) r.st = ST_RANGE;
        else release_chain(c.id, n);
      end
      OP_QUERY: begin
        if (c.blk >= n) r.st = ST_RANGE;
        else r.fl = !blk_free(c.blk);
      end
      OP_HEAD: begin
        r.id = c.id;
        if (c.id >= n) r.st = ST_RANGE;
        else if (!head_ok[c.id]) r.st = ST_EMPTY;
        else r.blk = head_blk[c.id];
      end
      OP_NEXT: begin
        if (c.blk >= n) r.st = ST_RANGE;
        else if (is_last[c.blk]) r.fl = 1'b1;
        else r.blk = next_blk[c.blk];
      end
      default: r.st = ST_RANGE;
    endcase
    return r;
  endfunction

  // A get next must never land on a link that was never written.
  function automatic cmd_t legalize(cmd_t c);
    int n, s;
    n = pool_n();
    if (c.op != OP_NEXT || c.blk >= n || link_set[c.blk]) return c;
    s = $urandom_range(0, n - 1);
    for (int k = 0; k < n; k++) begin
      if (link_set[(s + k) % n]) begin
        c.blk = 8'((s + k) % n);
        return c;
      end
    end
    if (n < 256) c.blk = 8'(n);
    else c.op = OP_QUERY;
    return c;
  endfunction

  function automatic cmd_t random_cmd(int n, int bs);
    cmd_t c;
    int pick, k;
    pick = $urandom_range(0, 99);
    if (pick < 26) c.op = OP_WRITE;
    else if (pick < 44) c.op = OP_APPEND;
    else if (pick < 60) c.op = OP_REMOVE;
    else if (pick < 72) c.op = OP_QUERY;
    else if (pick < 83) c.op = OP_HEAD;
    else if (pick < 97) c.op = OP_NEXT;
    else c.op = 3'($urandom_range(6, 7));
    c.id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, n - 1));
    c.blk = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, n - 1));
    pick = $urandom_range(0, 19);
    if (pick == 0) c.size = '0;
    else if (pick == 1) c.size = 24'($urandom);
    else begin
      k = $urandom_range(0, (n / 3) + 1);
      c.size = 24'(k * bs + $urandom_range(1, (bs > 0) ? bs : 1));
    end
    return c;
  endfunction

  // Results are checked before the newly accepted item is predicted.
  always @(posedge clk_i) begin
    res_t e;
    cmd_t c;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result, status %0d", $time, status_o);
          failed = 1;
        end else begin
          e = pending_q.pop_front();
          if (status_o !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, status_o);
            failed = 1;
          end
          if (id_out_o !== e.id) begin
            $display("%0t: id_out expected %0d actual %0d", $time, e.id, id_out_o);
            failed = 1;
          end
          if (block_out_o !== e.blk) begin
            $display("%0t: block_out expected %0d actual %0d", $time, e.blk, block_out_o);
            failed = 1;
          end
          if (flag_o !== e.fl) begin
            $display("%0t: flag expected %0d actual %0d", $time, e.fl, flag_o);
            failed = 1;
          end
          if (last_fill_o !== e.fill) begin
            $display("%0t: last_fill expected %0d actual %0d", $time, e.fill, last_fill_o);
            failed = 1;
          end
          if (blocks_taken_o !== e.taken) begin
            $display("%0t: blocks_taken expected %0d actual %0d", $time, e.taken,
                     blocks_taken_o);
            failed = 1;
          end
        end
      end
      if (start_i && !busy_o) begin
        c = '{opcode_i, data_id_i, block_index_i, data_size_i};
        pending_q.insert(pending_q.size(), predict_result(c));
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_ACTIVE) pool_active = cfg_data_i[8:0];
        else pool_bsize = cfg_data_i;
      end
    end
    took <= rst_ni && start_i && !busy_o;
  end

  // Command driver with random idle bursts.
  always @(negedge clk_i) begin
    cmd_t c;
    if (rst_ni && !(start_i && !took)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else if (cmd_q.size() != 0 && !quiet && $urandom_range(0, 4) == 0) begin
        gap_left <= $urandom_range(0, 18);
        start_i <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        c = legalize(cmd_q.pop_front());
        opcode_i <= c.op;
        data_id_i <= c.id;
        block_index_i <= c.blk;
        data_size_i <= c.size;
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic idx, logic [CFGW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || start_i || pending_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic add(logic [OPW-1:0] op, int id, int blk, int size);
    cmd_q.insert(cmd_q.size(), '{op, 8'(id), 8'(blk), 24'(size)});
  endtask

  task automatic run_phase(int act, int bs, int count, bit no_gaps);
    drain();
    write_reg(CFG_ACTIVE, CFGW'(act));
    write_reg(CFG_BSIZE, CFGW'(bs));
    quiet = no_gaps;
    for (int k = 0; k < count; k++)
      cmd_q.insert(cmd_q.size(), random_cmd((act > 256) ? 256 : act, bs));
  endtask

  initial begin
    for (int i = 0; i < 4; i++) free_words[i] = '1;
    for (int i = 0; i < 256; i++) begin
      head_blk[i] = '0;
      head_ok[i] = 1'b0;
      next_blk[i] = '0;
      is_last[i] = 1'b0;
      link_set[i] = 1'b0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset configuration.
    add(OP_WRITE, 0, 0, 1);
    add(OP_WRITE, 255, 0, 24'hFFFFFF);
    add(OP_WRITE, 1, 0, 192);
    add(OP_NEXT, 0, 0, 0);
    add(OP_NEXT, 0, 1, 0);
    add(OP_WRITE, 1, 0, 65);
    add(OP_APPEND, 0, 0, 128);
    add(OP_APPEND, 0, 0, 0);
    add(OP_WRITE, 2, 0, 0);
    add(OP_HEAD, 1, 0, 0);
    add(OP_HEAD, 9, 0, 0);
    add(OP_REMOVE, 1, 0, 0);
    add(OP_QUERY, 0, 0, 0);
    add(OP_QUERY, 0, 255, 0);
    add(OP_WRITE, 3, 0, 256 * 64);
    add(OP_APPEND, 0, 0, 64);
    add(6, 0, 0, 0);
    add(7, 255, 255, 24'hFFFFFF);

    // Small pool: out-of-range indexes, then random traffic.
    drain();
    write_reg(CFG_ACTIVE, 16);
    write_reg(CFG_BSIZE, 1);
    add(OP_WRITE, 255, 0, 5);
    add(OP_REMOVE, 20, 0, 0);
    add(OP_HEAD, 200, 0, 0);
    add(OP_QUERY, 0, 200, 0);
    add(OP_NEXT, 0, 200, 0);
    for (int k = 0; k < 110; k++) cmd_q.insert(cmd_q.size(), random_cmd(16, 1));

    // One ID only: append finds no empty ID once it is used.
    drain();
    write_reg(CFG_ACTIVE, 1);
    write_reg(CFG_BSIZE, 16'hFFFF);
    add(OP_APPEND, 0, 0, 24'hFFFFFF);
    add(OP_APPEND, 0, 0, 3);
    add(OP_APPEND, 0, 0, 3);
    for (int k = 0; k < 30; k++) cmd_q.insert(cmd_q.size(), random_cmd(1, 65535));

    // Zero block size runs short of space for any nonzero size.
    drain();
    write_reg(CFG_BSIZE, 0);
    write_reg(CFG_ACTIVE, 12);
    add(OP_WRITE, 0, 0, 10);
    add(OP_APPEND, 0, 0, 10);

    run_phase(8, 3, 130, 0);
    run_phase(256, 64, 30, 0);
    run_phase(32, 200, 140, 0);
    run_phase(511, 4096, 20, 0);
    run_phase(64, 16, 80, 0);
    run_phase(20, 7, 90, 1);

    drain();
    repeat (1500) @(negedge clk_i);
    if (!failed) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #100ms;
    $display("Verification failed");
    $finish;
  end

endmodule
